>>> hdl/spk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_pkg
// Shared constants, types and rotate helpers for the Speck 32/64 cipher.
// ----------------------------------------------------------------------------
package spk_pkg;

   // cipher geometry
   localparam int MAX_ROUNDS = 32;
   localparam int ROT_ALPHA  = 7;
   localparam int ROT_BETA   = 2;

   localparam int WORD_W      = 16;
   localparam int BLOCK_W     = 2 * WORD_W;
   localparam int KEY_W       = 4 * WORD_W;
   localparam int RCNT_CFG_W  = 6;
   localparam int KEY_IDX_W   = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int RCNT_W      = $clog2(MAX_ROUNDS + 1);
   localparam int RCNT_RESET  = (22 > MAX_ROUNDS) ? MAX_ROUNDS : 22;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = KEY_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_KEY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 2'd1;

   // operation select
   localparam logic FUNC_ENC = 1'b0;
   localparam logic FUNC_DEC = 1'b1;

   // operands of the shared round unit
   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] key;
      logic              func;
   } round_op_type;

   // result of the shared round unit
   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
   } round_res_type;

   // round key table write beat
   typedef struct packed {
      logic                 we;
      logic [KEY_IDX_W-1:0] addr;
      logic [WORD_W-1:0]    data;
   } key_wr_type;

   // rotate right by a constant amount
   function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
      logic [2*WORD_W-1:0] w;
      w = {v, v} >> amt;
      return w[WORD_W-1:0];
   endfunction

   // rotate left by a constant amount
   function automatic logic [WORD_W-1:0] rot_l(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
      return rot_r(v, WORD_W - amt);
   endfunction

endpackage

>>> hdl/spk_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_round
// Shared Speck round: one encryption or one decryption round per cycle.
// The key schedule borrows it in encrypt mode with the round index as key.
// ----------------------------------------------------------------------------
module spk_round (
   input  spk_pkg::round_op_type  op,
   output spk_pkg::round_res_type res
);

   logic [spk_pkg::WORD_W-1:0] enc_sum;
   logic [spk_pkg::WORD_W-1:0] enc_x;
   logic [spk_pkg::WORD_W-1:0] enc_y;
   logic [spk_pkg::WORD_W-1:0] dec_y;
   logic [spk_pkg::WORD_W-1:0] dec_diff;
   logic [spk_pkg::WORD_W-1:0] dec_x;

   // forward round
   assign enc_sum = spk_pkg::rot_r(op.x, spk_pkg::ROT_ALPHA) + op.y;
   assign enc_x   = enc_sum ^ op.key;
   assign enc_y   = spk_pkg::rot_l(op.y, spk_pkg::ROT_BETA) ^ enc_x;

   // inverse round
   assign dec_y    = spk_pkg::rot_r(op.x ^ op.y, spk_pkg::ROT_BETA);
   assign dec_diff = (op.x ^ op.key) - dec_y;
   assign dec_x    = spk_pkg::rot_l(dec_diff, spk_pkg::ROT_ALPHA);

   // direction select
   always_comb begin
      if (op.func == spk_pkg::FUNC_DEC) begin
         res.x = dec_x;
         res.y = dec_y;
      end else begin
         res.x = enc_x;
         res.y = enc_y;
      end
   end

endmodule

>>> hdl/spk_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_key_ram
// Round key table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spk_key_ram (
   input  logic                              clock,
   input  spk_pkg::key_wr_type               wr,
   input  logic [spk_pkg::KEY_IDX_W-1:0]     rd_addr,
   output logic [spk_pkg::WORD_W-1:0]        rd_data
);

   logic [spk_pkg::WORD_W-1:0] key_mem_ff [spk_pkg::MAX_ROUNDS];
   logic [spk_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         key_mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/spk_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_key_sched
// Key expansion sequencer: one round key per cycle through the shared round
// unit, written into the round key table.
// ----------------------------------------------------------------------------
module spk_key_sched (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [spk_pkg::KEY_W-1:0]       master_key,
   input  spk_pkg::round_res_type          res,
   output logic                            busy,
   output spk_pkg::round_op_type           op,
   output spk_pkg::key_wr_type             wr
);

   localparam logic [spk_pkg::KEY_IDX_W-1:0] LAST_IDX =
      spk_pkg::KEY_IDX_W'(spk_pkg::MAX_ROUNDS - 1);

   logic                            busy_ff;
   logic                            busy_in;
   logic [spk_pkg::KEY_IDX_W-1:0]   idx_ff;
   logic [spk_pkg::KEY_IDX_W-1:0]   idx_in;
   logic [spk_pkg::WORD_W-1:0]      k_ff;
   logic [spk_pkg::WORD_W-1:0]      k_in;
   logic [spk_pkg::WORD_W-1:0]      l0_ff;
   logic [spk_pkg::WORD_W-1:0]      l0_in;
   logic [spk_pkg::WORD_W-1:0]      l1_ff;
   logic [spk_pkg::WORD_W-1:0]      l1_in;
   logic [spk_pkg::WORD_W-1:0]      l2_ff;
   logic [spk_pkg::WORD_W-1:0]      l2_in;

   // next state: load on start, else advance one schedule round while busy
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      k_in    = k_ff;
      l0_in   = l0_ff;
      l1_in   = l1_ff;
      l2_in   = l2_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         k_in    = master_key[15:0];
         l0_in   = master_key[31:16];
         l1_in   = master_key[47:32];
         l2_in   = master_key[63:48];
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         k_in   = res.y;
         l0_in  = l1_ff;
         l1_in  = l2_ff;
         l2_in  = res.x;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // schedule words
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      k_ff   <= k_in;
      l0_ff  <= l0_in;
      l1_ff  <= l1_in;
      l2_ff  <= l2_in;
   end

   // round unit operands: l0 as x, k as y, round index as key
   assign op.x    = l0_ff;
   assign op.y    = k_ff;
   assign op.key  = spk_pkg::WORD_W'(idx_ff);
   assign op.func = spk_pkg::FUNC_ENC;

   // table write of the current key
   assign wr.we   = busy_ff;
   assign wr.addr = idx_ff;
   assign wr.data = k_ff;

   assign busy = busy_ff;

endmodule

>>> hdl/speck32_64_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck32_64_cipher
// Speck 32/64 block cipher with a stored round key table and one shared
// round unit.
// ----------------------------------------------------------------------------
// Usage
//  - csr_we/csr_index/csr_wdata write master_key (index 0) or round_count
//    (index 1). Each such write re-expands the key into the round key table,
//    one key per cycle for all MAX_ROUNDS (32) table entries; req_stall is high then.
//    Writes to other indexes are ignored.
//  - req channel: a beat carries req_func (0 encrypt, 1 decrypt) and
//    req_block_in (x in bits 31:16, y in bits 15:0).
//  - rsp channel: one beat per request, rsp_block_out in the same layout.
//  - A block runs n rounds, n being round_count clipped to 32, one round per
//    cycle through the shared round unit; the result shows on rsp the cycle
//    after the last round if the output register is free. A new request is
//    taken only after the result is handed to the output register.
//    round_count of zero passes the block through unchanged.
//  - rsp is a registered output: a waiting result does not block the next
//    request. If a result finishes while the output register still holds a
//    stalled beat, it is kept and req_stall stays high until it moves on.
//  - reset clears the sequencers and sets round_count to 22. The round key
//    table is not defined until the first configuration write.
// ----------------------------------------------------------------------------
module speck32_64_cipher (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [spk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spk_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [spk_pkg::BLOCK_W-1:0]        req_block_in,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [spk_pkg::BLOCK_W-1:0]        rsp_block_out
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                       state_ff;
   logic [1:0]                       state_in;
   logic [spk_pkg::KEY_W-1:0]        master_key_ff;
   logic [spk_pkg::KEY_W-1:0]        master_key_in;
   logic [spk_pkg::RCNT_W-1:0]       rounds_ff;
   logic [spk_pkg::RCNT_W-1:0]       rounds_in;
   logic [spk_pkg::WORD_W-1:0]       x_ff;
   logic [spk_pkg::WORD_W-1:0]       x_in;
   logic [spk_pkg::WORD_W-1:0]       y_ff;
   logic [spk_pkg::WORD_W-1:0]       y_in;
   logic                             func_ff;
   logic                             func_in;
   logic [spk_pkg::RCNT_W-1:0]       rnd_ff;
   logic [spk_pkg::RCNT_W-1:0]       rnd_in;
   logic [spk_pkg::KEY_IDX_W-1:0]    idx_ff;
   logic [spk_pkg::KEY_IDX_W-1:0]    idx_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [spk_pkg::BLOCK_W-1:0]      rsp_block_ff;
   logic [spk_pkg::BLOCK_W-1:0]      rsp_block_in;

   logic                             csr_key_wr;
   logic                             csr_cnt_wr;
   logic                             sched_start;
   logic                             sched_busy;
   logic [spk_pkg::RCNT_CFG_W:0]     cnt_cfg;
   logic                             accept;
   logic                             out_free;
   logic                             out_load;
   logic                             last_round;
   logic [spk_pkg::KEY_IDX_W-1:0]    first_idx;
   logic [spk_pkg::KEY_IDX_W-1:0]    next_idx;
   logic [spk_pkg::KEY_IDX_W-1:0]    rd_addr;
   logic [spk_pkg::WORD_W-1:0]       rd_key;

   spk_pkg::round_op_type            sched_op;
   spk_pkg::round_op_type            unit_op;
   spk_pkg::round_res_type           unit_res;
   spk_pkg::key_wr_type              key_wr;

   // configuration decode
   assign csr_key_wr  = csr_we && !reset && (csr_index == spk_pkg::CSR_MASTER_KEY);
   assign csr_cnt_wr  = csr_we && !reset && (csr_index == spk_pkg::CSR_ROUND_COUNT);
   assign sched_start = csr_key_wr || csr_cnt_wr;
   assign cnt_cfg     = {1'b0, csr_wdata[spk_pkg::RCNT_CFG_W-1:0]};

   always_comb begin
      master_key_in = master_key_ff;
      rounds_in     = rounds_ff;
      if (csr_key_wr) begin
         master_key_in = csr_wdata;
      end
      if (csr_cnt_wr) begin
         if (cnt_cfg > (spk_pkg::RCNT_CFG_W + 1)'(spk_pkg::MAX_ROUNDS)) begin
            rounds_in = spk_pkg::RCNT_W'(spk_pkg::MAX_ROUNDS);
         end else begin
            rounds_in = spk_pkg::RCNT_W'(cnt_cfg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_key_ff <= '0;
         rounds_ff     <= spk_pkg::RCNT_W'(spk_pkg::RCNT_RESET);
      end else begin
         master_key_ff <= master_key_in;
         rounds_ff     <= rounds_in;
      end
   end

   // key expansion
   spk_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (sched_start),
      .master_key (master_key_in),
      .res        (unit_res),
      .busy       (sched_busy),
      .op         (sched_op),
      .wr         (key_wr)
   );

   // round key table
   spk_key_ram u_key_ram (
      .clock   (clock),
      .wr      (key_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   // shared round unit, lent to the key schedule while it runs
   always_comb begin
      if (sched_busy) begin
         unit_op = sched_op;
      end else begin
         unit_op.x    = x_ff;
         unit_op.y    = y_ff;
         unit_op.key  = rd_key;
         unit_op.func = func_ff;
      end
   end

   spk_round u_round (
      .op  (unit_op),
      .res (unit_res)
   );

   // handshake
   assign req_stall  = reset || sched_busy || (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_round = (rnd_ff == spk_pkg::RCNT_W'(1));

   // key read address, issued in the cycle before the round that uses it
   always_comb begin
      if (req_func == spk_pkg::FUNC_DEC) begin
         first_idx = spk_pkg::KEY_IDX_W'(rounds_ff - spk_pkg::RCNT_W'(1));
      end else begin
         first_idx = '0;
      end
      if (func_ff == spk_pkg::FUNC_DEC) begin
         next_idx = idx_ff - 1'b1;
      end else begin
         next_idx = idx_ff + 1'b1;
      end
      if (state_ff == ST_IDLE) begin
         rd_addr = first_idx;
      end else begin
         rd_addr = next_idx;
      end
   end

   // block sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      func_in      = func_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      out_load     = 1'b0;
      rsp_block_in = rsp_block_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = req_block_in[31:16];
               y_in    = req_block_in[15:0];
               func_in = req_func;
               rnd_in  = rounds_ff;
               idx_in  = first_idx;
               if (rounds_ff == '0) begin
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            x_in   = unit_res.x;
            y_in   = unit_res.y;
            idx_in = next_idx;
            rnd_in = rnd_ff - 1'b1;
            if (last_round) begin
               if (out_free) begin
                  out_load     = 1'b1;
                  rsp_block_in = {unit_res.x, unit_res.y};
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_block_in = {x_ff, y_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      func_ff      <= func_in;
      rnd_ff       <= rnd_in;
      idx_ff       <= idx_in;
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

endmodule

>>> hdl/spk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks for the Speck 32/64 cipher, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_we,
   input logic [spk_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [spk_pkg::BLOCK_W-1:0]        rsp_block_out
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out))
      else $error("rsp beat changed while stalled");

   // one block at a time: no request taken right after one is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous block in flight");

   // key expansion blocks requests after a key or round count write
   assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == spk_pkg::CSR_MASTER_KEY ||
                 csr_index == spk_pkg::CSR_ROUND_COUNT) |=> req_stall)
      else $error("request channel open during key expansion");

   // no response beat right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind speck32_64_cipher spk_checker u_spk_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_we        (csr_we),
   .csr_index     (csr_index),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_block_out (rsp_block_out)
);
